/* hdl/g128_pkg.sv */
`default_nettype none
package g128_pkg;

  localparam int unsigned BlockW    = 128;
  localparam int unsigned HalfW     = 64;
  localparam int unsigned RoundCntW = 6;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [CfgIdxW-1:0] CfgKeyHigh = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgKeyLow  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRounds  = 2'd2;

  localparam logic [RoundCntW-1:0] RoundsReset = 6'd40;

  localparam logic [3:0] Sbox [16] = '{
    4'h1, 4'ha, 4'h4, 4'hc, 4'h6, 4'hf, 4'h3, 4'h9,
    4'h2, 4'hd, 4'hb, 4'h7, 4'h5, 4'h0, 4'h8, 4'he
  };

  localparam logic [6:0] Perm16 [16] = '{
    7'd0,  7'd33, 7'd66, 7'd99, 7'd96, 7'd1,  7'd34, 7'd67,
    7'd64, 7'd97, 7'd2,  7'd35, 7'd32, 7'd65, 7'd98, 7'd3
  };

  typedef struct packed {
    logic                 vld;
    logic [RoundCntW-1:0] left;
    logic [RoundCntW-1:0] rc;
  } g128_ctl_t;

  function automatic logic [BlockW-1:0] sub_cells(input logic [BlockW-1:0] s);
    logic [BlockW-1:0] r;
    for (int n = 0; n < BlockW / 4; n++) begin
      r[4*n +: 4] = Sbox[s[4*n +: 4]];
    end
    return r;
  endfunction

  function automatic logic [BlockW-1:0] perm_bits(input logic [BlockW-1:0] s);
    logic [BlockW-1:0] r;
    r = '0;
    for (int i = 0; i < BlockW; i++) begin
      r[Perm16[i % 16] + 7'(4 * (i / 16))] = s[i];
    end
    return r;
  endfunction

  function automatic logic [RoundCntW-1:0] rc_step(input logic [RoundCntW-1:0] rc);
    return {rc[4:0], rc[5] ^ rc[4] ^ 1'b1};
  endfunction

  // U = key[95:64] at bits 4i+2, V = key[31:0] at bits 4i+1, rc bit j at 4j+3
  function automatic logic [BlockW-1:0] add_round_key(input logic [BlockW-1:0] s,
                                                      input logic [BlockW-1:0] k,
                                                      input logic [RoundCntW-1:0] rc);
    logic [BlockW-1:0] r;
    r = s;
    for (int i = 0; i < 32; i++) begin
      r[4*i+2] = r[4*i+2] ^ k[64+i];
      r[4*i+1] = r[4*i+1] ^ k[i];
    end
    for (int j = 0; j < RoundCntW; j++) begin
      r[4*j+3] = r[4*j+3] ^ rc[j];
    end
    r[BlockW-1] = ~r[BlockW-1];
    return r;
  endfunction

  function automatic logic [BlockW-1:0] key_update(input logic [BlockW-1:0] k);
    return {k[17:16], k[31:18], k[11:0], k[15:12], k[127:32]};
  endfunction

endpackage
`default_nettype wire

/* hdl/g128_round_cell.sv */
`default_nettype none
module g128_round_cell (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire g128_pkg::g128_ctl_t          ctl_i,
  input  wire logic [g128_pkg::BlockW-1:0]  state_i,
  input  wire logic [g128_pkg::BlockW-1:0]  key_i,
  output g128_pkg::g128_ctl_t               ctl_o,
  output logic      [g128_pkg::BlockW-1:0]  state_o,
  output logic      [g128_pkg::BlockW-1:0]  key_o
);
  import g128_pkg::*;

  g128_ctl_t         ctl_d, ctl_q;
  logic [BlockW-1:0] state_d, state_q;
  logic [BlockW-1:0] key_d, key_q;
  logic [RoundCntW-1:0] rc_n;
  logic              active;

  assign active = (ctl_i.left != '0);
  assign rc_n   = rc_step(ctl_i.rc);

  always_comb begin
    ctl_d.vld = ctl_i.vld;
    if (active) begin
      ctl_d.left = ctl_i.left - 1'b1;
      ctl_d.rc   = rc_n;
      state_d    = add_round_key(perm_bits(sub_cells(state_i)), key_i, rc_n);
      key_d      = key_update(key_i);
    end else begin
      ctl_d.left = ctl_i.left;
      ctl_d.rc   = ctl_i.rc;
      state_d    = state_i;
      key_d      = key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
    key_q   <= key_d;
  end

  assign ctl_o   = ctl_q;
  assign state_o = state_q;
  assign key_o   = key_q;

endmodule
`default_nettype wire

/* hdl/gift128_block_encrypt_unit.sv */
// Every word passes through every round cell from start to done, for any round count.
// Throughput: one word per cycle; busy_o stays low, one round cell per pipeline stage.
// Results appear on done_o for one cycle and cannot be stalled.
// Reset clears all pipeline valids; key resets to 0 and rounds_q to 40.
`default_nettype none
module gift128_block_encrypt_unit #(
  parameter int unsigned MAX_ROUNDS = 40
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [g128_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [g128_pkg::HalfW-1:0]    cfg_wdata_i,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [g128_pkg::HalfW-1:0]    plaintext_high_i,
  input  wire logic [g128_pkg::HalfW-1:0]    plaintext_low_i,
  output logic                               done_o,
  output logic      [g128_pkg::HalfW-1:0]    ciphertext_high_o,
  output logic      [g128_pkg::HalfW-1:0]    ciphertext_low_o
);
  import g128_pkg::*;

  localparam logic [RoundCntW-1:0] MaxRnd = RoundCntW'(MAX_ROUNDS);

  logic [HalfW-1:0]     key_high_q, key_low_q;
  logic [RoundCntW-1:0] rounds_q;
  logic [RoundCntW-1:0] rounds_sat;
  logic                 accept;

  g128_ctl_t         ctl   [MAX_ROUNDS+1];
  logic [BlockW-1:0] state [MAX_ROUNDS+1];
  logic [BlockW-1:0] key   [MAX_ROUNDS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      rounds_q   <= RoundsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgKeyHigh: key_high_q <= cfg_wdata_i;
        CfgKeyLow:  key_low_q  <= cfg_wdata_i;
        CfgRounds:  rounds_q   <= cfg_wdata_i[RoundCntW-1:0];
        default: ;
      endcase
    end
  end

  assign busy_o     = 1'b0;
  assign accept     = start_i && !busy_o;
  assign rounds_sat = (rounds_q > MaxRnd) ? MaxRnd : rounds_q;

  assign ctl[0].vld  = accept;
  assign ctl[0].left = rounds_sat;
  assign ctl[0].rc   = '0;
  assign state[0]    = {plaintext_high_i, plaintext_low_i};
  assign key[0]      = {key_high_q, key_low_q};

  for (genvar g = 0; g < MAX_ROUNDS; g++) begin : g_cell
    g128_round_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl[g]),
      .state_i (state[g]),
      .key_i   (key[g]),
      .ctl_o   (ctl[g+1]),
      .state_o (state[g+1]),
      .key_o   (key[g+1])
    );
  end

  assign done_o            = ctl[MAX_ROUNDS].vld;
  assign ciphertext_high_o = state[MAX_ROUNDS][BlockW-1:HalfW];
  assign ciphertext_low_o  = state[MAX_ROUNDS][HalfW-1:0];

  a_rounds_spent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ctl[MAX_ROUNDS].left == '0)
    else $error("rounds left at pipeline exit");

  a_first_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rst_ni |=> ctl[1].vld == $past(accept))
    else $error("first cell lost or invented a word");

  a_rounds_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rst_ni && cfg_we_i && cfg_idx_i == CfgRounds |=>
      rounds_q == $past(cfg_wdata_i[RoundCntW-1:0]))
    else $error("round count write dropped");

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import g128_pkg::*;

  localparam int unsigned MaxRounds   = 40;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomWords = 950;
  localparam int unsigned DirCount    = 20;

  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;
  localparam logic [HalfW-1:0]   AllOnes  = '1;

  localparam logic [3:0] SboxTab [16] = '{
    4'h1, 4'ha, 4'h4, 4'hc, 4'h6, 4'hf, 4'h3, 4'h9,
    4'h2, 4'hd, 4'hb, 4'h7, 4'h5, 4'h0, 4'h8, 4'he
  };
  localparam int unsigned BitMap [16] = '{
    0, 33, 66, 99, 96, 1, 34, 67, 64, 97, 2, 35, 32, 65, 98, 3
  };

  typedef struct packed {
    logic [HalfW-1:0] hi;
    logic [HalfW-1:0] lo;
  } ct_word_t;

  typedef struct packed {
    logic [HalfW-1:0] kh;
    logic [HalfW-1:0] kl;
    logic [HalfW-1:0] rounds_word;
    logic [HalfW-1:0] ph;
    logic [HalfW-1:0] pl;
    logic             known;
    logic [HalfW-1:0] ch;
    logic [HalfW-1:0] cl;
  } dir_row_t;

  // known rows: zero rounds passes the block through
  localparam dir_row_t DirRows [DirCount] = '{
    '{64'h0, 64'h0, 64'd40, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
    '{64'h0, 64'h0, 64'd40, AllOnes, AllOnes, 1'b0, 64'h0, 64'h0},
    '{64'h0, 64'h0, 64'd0, 64'h0, 64'h0, 1'b1, 64'h0, 64'h0},
    '{64'h0, 64'h0, 64'd0, AllOnes, AllOnes, 1'b1, AllOnes, AllOnes},
    '{64'h0, 64'h0, 64'd0, 64'h0123456789abcdef, 64'hfedcba9876543210,
      1'b1, 64'h0123456789abcdef, 64'hfedcba9876543210},
    '{AllOnes, AllOnes, 64'hffffffffffffffc0, AllOnes, 64'h0,
      1'b1, AllOnes, 64'h0},
    '{AllOnes, AllOnes, 64'hffffffffffffffc0, 64'h8000000000000001,
      64'h8000000000000001, 1'b1, 64'h8000000000000001, 64'h8000000000000001},
    '{64'h0, 64'h0, 64'd1, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
    '{64'h0, 64'h0, 64'd1, AllOnes, AllOnes, 1'b0, 64'h0, 64'h0},
    '{AllOnes, AllOnes, 64'd1, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
    '{AllOnes, AllOnes, 64'd1, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555,
      1'b0, 64'h0, 64'h0},
    '{64'h0123456789abcdef, 64'hfedcba9876543210, 64'd2, 64'h5555555555555555,
      64'haaaaaaaaaaaaaaaa, 1'b0, 64'h0, 64'h0},
    '{64'h0123456789abcdef, 64'hfedcba9876543210, 64'd40, 64'h0, 64'h0,
      1'b0, 64'h0, 64'h0},
    '{64'h0123456789abcdef, 64'hfedcba9876543210, 64'd40, AllOnes, AllOnes,
      1'b0, 64'h0, 64'h0},
    '{AllOnes, AllOnes, 64'd40, AllOnes, AllOnes, 1'b0, 64'h0, 64'h0},
    '{64'h0, AllOnes, 64'd41, 64'h1, 64'h0, 1'b0, 64'h0, 64'h0},
    '{AllOnes, 64'h0, 64'd63, 64'h0, 64'h8000000000000000, 1'b0, 64'h0, 64'h0},
    '{AllOnes, 64'h0, 64'd40, 64'h0, 64'h8000000000000000, 1'b0, 64'h0, 64'h0},
    '{64'h8000000000000000, 64'h1, 64'd39, 64'hdeadbeefcafef00d,
      64'h0f1e2d3c4b5a6978, 1'b0, 64'h0, 64'h0},
    '{64'h8000000000000000, 64'h1, 64'h1234567800000028, 64'hdeadbeefcafef00d,
      64'h0f1e2d3c4b5a6978, 1'b0, 64'h0, 64'h0}
  };

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [HalfW-1:0] cfg_wdata_i;
  logic             start_i;
  logic             busy_o;
  logic [HalfW-1:0] plaintext_high_i;
  logic [HalfW-1:0] plaintext_low_i;
  logic             done_o;
  logic [HalfW-1:0] ciphertext_high_o;
  logic [HalfW-1:0] ciphertext_low_o;

  gift128_block_encrypt_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .plaintext_high_i  (plaintext_high_i),
    .plaintext_low_i   (plaintext_low_i),
    .done_o            (done_o),
    .ciphertext_high_o (ciphertext_high_o),
    .ciphertext_low_o  (ciphertext_low_o)
  );

  ct_word_t         pending_ct [$];
  ct_word_t         got_ct;
  ct_word_t         head_ct;
  int unsigned      fails;
  int unsigned      cycles;
  logic [HalfW-1:0] key_hi_q;
  logic [HalfW-1:0] key_lo_q;
  logic [HalfW-1:0] rounds_word_q;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic logic [BlockW-1:0] encipher(input logic [BlockW-1:0] blk,
                                                 input logic [BlockW-1:0] key,
                                                 input logic [5:0] rounds);
    logic [BlockW-1:0] s;
    logic [BlockW-1:0] t;
    logic [BlockW-1:0] k;
    logic [5:0]        rc;
    logic [15:0]       w0;
    logic [15:0]       w1;
    int unsigned       nr;
    s  = blk;
    k  = key;
    rc = '0;
    nr = (rounds > MaxRounds) ? MaxRounds : rounds;
    for (int r = 0; r < nr; r++) begin
      rc = {rc[4:0], ~(rc[5] ^ rc[4])};
      for (int n = 0; n < 32; n++) begin
        t[4*n +: 4] = SboxTab[s[4*n +: 4]];
      end
      for (int i = 0; i < 128; i++) begin
        s[BitMap[i % 16] + 4 * (i / 16)] = t[i];
      end
      for (int i = 0; i < 32; i++) begin
        s[4*i+2] = s[4*i+2] ^ k[64+i];
        s[4*i+1] = s[4*i+1] ^ k[i];
      end
      for (int j = 0; j < 6; j++) begin
        s[4*j+3] = s[4*j+3] ^ rc[j];
      end
      s[127] = ~s[127];
      w0 = k[15:0];
      w1 = k[31:16];
      k  = {w1[1:0], w1[15:2], w0[11:0], w0[15:12], k[127:32]};
    end
    return s;
  endfunction

  function automatic logic [HalfW-1:0] rand_word();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic settle();
    start_i <= 1'b0;
    while (pending_ct.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_key_rounds(input logic [HalfW-1:0] kh, input logic [HalfW-1:0] kl,
                                 input logic [HalfW-1:0] rw);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgKeyHigh;
    cfg_wdata_i <= kh;
    @(posedge clk_i);
    cfg_idx_i   <= CfgKeyLow;
    cfg_wdata_i <= kl;
    @(posedge clk_i);
    cfg_idx_i   <= CfgRounds;
    cfg_wdata_i <= rw;
    @(posedge clk_i);
    // unmapped index, must not disturb anything
    cfg_idx_i   <= CfgSpare;
    cfg_wdata_i <= {$urandom, $urandom};
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    key_hi_q      <= kh;
    key_lo_q      <= kl;
    rounds_word_q <= rw;
  endtask

  task automatic send_block(input logic [HalfW-1:0] ph, input logic [HalfW-1:0] pl,
                            input ct_word_t want, input int unsigned gap);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i          <= 1'b1;
    plaintext_high_i <= ph;
    plaintext_low_i  <= pl;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_ct.push_back(want);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      got_ct = '{hi: ciphertext_high_o, lo: ciphertext_low_o};
      if (pending_ct.size() == 0) begin
        fails++;
        $display("%0t: unexpected word, expected none, actual %h_%h", $time,
                 got_ct.hi, got_ct.lo);
      end else begin
        head_ct = pending_ct.pop_front();
        if (got_ct.hi !== head_ct.hi) begin
          fails++;
          $display("%0t: ciphertext_high expected %h actual %h", $time,
                   head_ct.hi, got_ct.hi);
        end
        if (got_ct.lo !== head_ct.lo) begin
          fails++;
          $display("%0t: ciphertext_low expected %h actual %h", $time,
                   head_ct.lo, got_ct.lo);
        end
      end
    end
  end

  initial begin
    int unsigned      sent;
    int unsigned      burst;
    bit               no_gaps;
    logic [HalfW-1:0] kh;
    logic [HalfW-1:0] kl;
    logic [HalfW-1:0] rw;
    logic [HalfW-1:0] ph;
    logic [HalfW-1:0] pl;
    ct_word_t         want;

    fails            = 0;
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= CfgKeyHigh;
    cfg_wdata_i      <= '0;
    start_i          <= 1'b0;
    plaintext_high_i <= '0;
    plaintext_low_i  <= '0;
    key_hi_q         <= '0;
    key_lo_q         <= '0;
    rounds_word_q    <= HalfW'(RoundsReset);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirRows[r]) begin
      if (DirRows[r].kh != key_hi_q || DirRows[r].kl != key_lo_q ||
          DirRows[r].rounds_word != rounds_word_q) begin
        settle();
        load_key_rounds(DirRows[r].kh, DirRows[r].kl, DirRows[r].rounds_word);
      end
      if (DirRows[r].known)
        want = '{hi: DirRows[r].ch, lo: DirRows[r].cl};
      else
        want = encipher({DirRows[r].ph, DirRows[r].pl}, {DirRows[r].kh, DirRows[r].kl},
                        DirRows[r].rounds_word[5:0]);
      send_block(DirRows[r].ph, DirRows[r].pl, want, $urandom_range(0, 14));
    end

    sent = 0;
    while (sent < RandomWords) begin
      settle();
      kh = rand_word();
      kl = rand_word();
      rw = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
      case ($urandom_range(0, 7))
        0: rw[5:0] = 6'd0;
        1: rw[5:0] = 6'd1;
        2: rw[5:0] = 6'd40;
        3: rw[5:0] = 6'($urandom_range(41, 63));
        default: rw[5:0] = 6'($urandom_range(1, 40));
      endcase
      load_key_rounds(kh, kl, rw);
      burst   = $urandom_range(10, 60);
      no_gaps = ($urandom_range(0, 2) == 0);
      repeat (burst) begin
        ph   = rand_word();
        pl   = rand_word();
        want = encipher({ph, pl}, {kh, kl}, rw[5:0]);
        send_block(ph, pl, want, no_gaps ? 0 : $urandom_range(0, 14));
        sent++;
      end
    end

    settle();
    repeat (MaxRounds + 16) @(posedge clk_i);
    if (fails == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
hdl/g128_pkg.sv
hdl/g128_round_cell.sv
hdl/gift128_block_encrypt_unit.sv
tb/sv/testbench.sv
